[sv/rbcm_pkg.sv]
// Package for the red blob centroid motion unit.
// Holds command/status types, register indexes and fixed widths; no dependencies.
`timescale 1ns / 1ps

package rbcm_pkg;

    // Fixed field widths
    localparam int COLOUR_W   = 8;
    localparam int INTEN_W    = 10;
    localparam int COUNT_W    = 22;
    localparam int SUM_W      = 32;
    localparam int THRESH_W   = 23;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 2;

    // Divider iteration count (one quotient bit per cycle)
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RED_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_HIGH = 2'd3;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0]  RST_MIN_RED_COUNT  = 22'd500;
    localparam logic [THRESH_W-1:0] RST_MOVE_THRESHOLD = 23'd100;
    localparam logic [INTEN_W-1:0]  RST_INTENSITY_LOW  = 10'd30;
    localparam logic [INTEN_W-1:0]  RST_INTENSITY_HIGH = 10'd400;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic acc_en;        // pixel transaction accepted
        logic snap;          // frame end: capture totals, clear accumulators
        logic div_load_row;  // start dividing the row sum
        logic div_load_col;  // start dividing the column sum
        logic div_step;      // one quotient bit
        logic store_row;     // keep row quotient
        logic store_col;     // keep column quotient
        logic sq_en;         // register squared displacements
        logic update;        // update moved flag and previous centroid
        logic out_load;      // load the result register
    } rbcm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic detected;
    } rbcm_status_t;

endpackage

[sv/rbcm_ctrl.sv]
// Controller for the red blob centroid motion unit.
// Sequences accumulation, division, displacement and result hand-off; uses rbcm_pkg.
`timescale 1ns / 1ps

module rbcm_ctrl
    import rbcm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_frame_end,
    output logic         m_valid,
    input  logic         m_ready,
    input  rbcm_status_t status,
    output rbcm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_CHECK,
        ST_DIV_ROW,
        ST_LOAD_COL,
        ST_DIV_COL,
        ST_STORE_COL,
        ST_SQUARE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign s_ready  = (state_reg == ST_ACCUM);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_ACCUM: begin
                if (s_valid) begin
                    cmd.acc_en = 1'b1;
                    if (s_frame_end) begin
                        cmd.snap   = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (status.detected) begin
                    cmd.div_load_row = 1'b1;
                    cnt_next         = '0;
                    state_next       = ST_DIV_ROW;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_ROW: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_LOAD_COL;
                end
            end
            ST_LOAD_COL: begin
                cmd.store_row    = 1'b1;
                cmd.div_load_col = 1'b1;
                cnt_next         = '0;
                state_next       = ST_DIV_COL;
            end
            ST_DIV_COL: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_STORE_COL;
                end
            end
            ST_STORE_COL: begin
                cmd.store_col = 1'b1;
                state_next    = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.sq_en  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output register is free
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[sv/rbcm_datapath.sv]
// Datapath for the red blob centroid motion unit: classifier, accumulators,
// serial divider, displacement test and result register. Uses rbcm_pkg.
`timescale 1ns / 1ps

module rbcm_datapath
    import rbcm_pkg::*;
#(
    parameter int ROW_BITS = 11,
    parameter int COL_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rbcm_cmd_t             cmd,
    output rbcm_status_t          status,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [COLOUR_W-1:0]   s_red,
    input  logic [COLOUR_W-1:0]   s_green,
    input  logic [COLOUR_W-1:0]   s_blue,
    input  logic [ROW_BITS-1:0]   s_pixel_row,
    input  logic [COL_BITS-1:0]   s_pixel_col,
    output logic                  m_detected,
    output logic                  m_moved,
    output logic [ROW_BITS-1:0]   m_center_row,
    output logic [COL_BITS-1:0]   m_center_col,
    output logic [COUNT_W-1:0]    m_red_total
);

    localparam int DIFF_W = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DISP_W = ((SQ_W + 1) > THRESH_W) ? (SQ_W + 1) : THRESH_W;

    // Configuration registers
    logic [COUNT_W-1:0]  min_red_count_reg;
    logic [THRESH_W-1:0] move_threshold_reg;
    logic [INTEN_W-1:0]  intensity_low_reg, intensity_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_red_count_reg  <= RST_MIN_RED_COUNT;
            move_threshold_reg <= RST_MOVE_THRESHOLD;
            intensity_low_reg  <= RST_INTENSITY_LOW;
            intensity_high_reg <= RST_INTENSITY_HIGH;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_MIN_RED_COUNT:  min_red_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_MOVE_THRESHOLD: move_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_INTENSITY_LOW:  intensity_low_reg  <= cfg_data[INTEN_W-1:0];
                REG_INTENSITY_HIGH: intensity_high_reg <= cfg_data[INTEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the pixel
    logic [INTEN_W-1:0] inten;
    logic [12:0]        red_x20, inten_x9;
    logic [11:0]        red_x10, green_x13, blue_x13;
    logic               is_red;

    always_comb begin
        inten     = {2'b00, s_red} + {2'b00, s_green} + {2'b00, s_blue};
        red_x20   = {5'b0, s_red} * 13'd20;
        inten_x9  = {3'b0, inten} * 13'd9;
        red_x10   = {4'b0, s_red} * 12'd10;
        green_x13 = {4'b0, s_green} * 12'd13;
        blue_x13  = {4'b0, s_blue} * 12'd13;
        is_red    = (inten > intensity_low_reg) && (inten < intensity_high_reg) &&
                    (red_x20 > inten_x9) && (red_x10 > green_x13) &&
                    (red_x10 > blue_x13);
    end

    // Saturating accumulators
    logic [COUNT_W-1:0] count_reg, count_add;
    logic [SUM_W-1:0]   row_sum_reg, col_sum_reg, row_add, col_add;
    logic [SUM_W:0]     row_wide, col_wide;

    always_comb begin
        count_add = count_reg;
        row_add   = row_sum_reg;
        col_add   = col_sum_reg;
        row_wide  = {1'b0, row_sum_reg} + {{(SUM_W + 1 - ROW_BITS){1'b0}}, s_pixel_row};
        col_wide  = {1'b0, col_sum_reg} + {{(SUM_W + 1 - COL_BITS){1'b0}}, s_pixel_col};
        if (is_red) begin
            if (count_reg != {COUNT_W{1'b1}}) begin
                count_add = count_reg + 1'b1;
            end
            row_add = row_wide[SUM_W] ? {SUM_W{1'b1}} : row_wide[SUM_W-1:0];
            col_add = col_wide[SUM_W] ? {SUM_W{1'b1}} : col_wide[SUM_W-1:0];
        end
    end

    // Frame totals captured at frame end
    logic [COUNT_W-1:0] frame_count_reg;
    logic [SUM_W-1:0]   frame_row_sum_reg, frame_col_sum_reg;
    logic               detected_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
        end else if (cmd.snap) begin
            count_reg   <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
        end else if (cmd.acc_en) begin
            count_reg   <= count_add;
            row_sum_reg <= row_add;
            col_sum_reg <= col_add;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            frame_count_reg   <= count_add;
            frame_row_sum_reg <= row_add;
            frame_col_sum_reg <= col_add;
            detected_reg      <= count_add > min_red_count_reg;
        end
    end

    assign status.detected = detected_reg;

    // Restoring divider, one quotient bit per cycle
    logic [SUM_W-1:0]   num_reg, quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W:0]   trial;
    logic               fits;

    always_comb begin
        trial = {rem_reg, num_reg[SUM_W-1]};
        fits  = trial >= {1'b0, frame_count_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load_row || cmd.div_load_col) begin
            num_reg <= cmd.div_load_row ? frame_row_sum_reg : frame_col_sum_reg;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[SUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            if (fits) begin
                rem_reg <= COUNT_W'(trial - {1'b0, frame_count_reg});
            end else begin
                rem_reg <= trial[COUNT_W-1:0];
            end
        end
    end

    // Clamp quotients to the coordinate range
    logic [ROW_BITS-1:0] cur_row_reg, row_clamped;
    logic [COL_BITS-1:0] cur_col_reg, col_clamped;

    always_comb begin
        row_clamped = (|quo_reg[SUM_W-1:ROW_BITS]) ? {ROW_BITS{1'b1}}
                                                  : quo_reg[ROW_BITS-1:0];
        col_clamped = (|quo_reg[SUM_W-1:COL_BITS]) ? {COL_BITS{1'b1}}
                                                  : quo_reg[COL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_row) begin
            cur_row_reg <= row_clamped;
        end
        if (cmd.store_col) begin
            cur_col_reg <= col_clamped;
        end
    end

    // Squared displacement from the previous centroid
    logic [ROW_BITS-1:0] prev_row_reg;
    logic [COL_BITS-1:0] prev_col_reg;
    logic                prev_valid_reg, moved_reg;
    logic [DIFF_W-1:0]   drow, dcol;
    logic [SQ_W-1:0]     sq_row_reg, sq_col_reg;
    logic [DISP_W-1:0]   disp;

    always_comb begin
        drow = (cur_row_reg > prev_row_reg)
             ? DIFF_W'(cur_row_reg - prev_row_reg) : DIFF_W'(prev_row_reg - cur_row_reg);
        dcol = (cur_col_reg > prev_col_reg)
             ? DIFF_W'(cur_col_reg - prev_col_reg) : DIFF_W'(prev_col_reg - cur_col_reg);
        disp = DISP_W'(sq_row_reg) + DISP_W'(sq_col_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_en) begin
            sq_row_reg <= drow * drow;
            sq_col_reg <= dcol * dcol;
        end
    end

    // Update moved flag and stored centroid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_row_reg   <= '0;
            prev_col_reg   <= '0;
            prev_valid_reg <= 1'b0;
            moved_reg      <= 1'b0;
        end else if (cmd.update) begin
            if (prev_valid_reg) begin
                moved_reg <= disp > DISP_W'(move_threshold_reg);
            end
            prev_row_reg   <= cur_row_reg;
            prev_col_reg   <= cur_col_reg;
            prev_valid_reg <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_detected   <= detected_reg;
            m_moved      <= moved_reg;
            m_center_row <= prev_row_reg;
            m_center_col <= prev_col_reg;
            m_red_total  <= frame_count_reg;
        end
    end

endmodule

[sv/red_blob_centroid_motion_unit.sv]
// Red blob centroid motion unit, top level: controller plus datapath.
// Depends on rbcm_pkg, rbcm_ctrl and rbcm_datapath.
`timescale 1ns / 1ps

// Pixels stream in at one per cycle while s_ready is high; each red pixel adds to
// a count and to the row and column sums. The pixel flagged frame_end closes the
// frame: s_ready then drops while the centroid is worked out by a shared
// bit-serial divider (first the row, then the column) and the squared displacement
// is tested, or only while the detection is checked when nothing is detected, and
// through any wait for the previous result to leave the output register.
// One result transaction leaves per frame through a registered output; the
// next frame's pixels are taken while that result still waits on m_ready.
// Configuration writes are always accepted and belong between frames.

module red_blob_centroid_motion_unit
    import rbcm_pkg::*;
#(
    parameter int ROW_BITS = 11,
    parameter int COL_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COLOUR_W-1:0]   s_red,
    input  logic [COLOUR_W-1:0]   s_green,
    input  logic [COLOUR_W-1:0]   s_blue,
    input  logic [ROW_BITS-1:0]   s_pixel_row,
    input  logic [COL_BITS-1:0]   s_pixel_col,
    input  logic                  s_frame_end,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_detected,
    output logic                  m_moved,
    output logic [ROW_BITS-1:0]   m_center_row,
    output logic [COL_BITS-1:0]   m_center_col,
    output logic [COUNT_W-1:0]    m_red_total
);

    rbcm_cmd_t    cmd;
    rbcm_status_t status;

    assign cfg_ready = 1'b1;

    rbcm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_frame_end (s_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    rbcm_datapath #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_pixel_row  (s_pixel_row),
        .s_pixel_col  (s_pixel_col),
        .m_detected   (m_detected),
        .m_moved      (m_moved),
        .m_center_row (m_center_row),
        .m_center_col (m_center_col),
        .m_red_total  (m_red_total)
    );

`ifndef SYNTHESIS
    // Closing a frame stops the pixel stream for the centroid work
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_frame_end) |=> !s_ready)
        else $error("pixel accepted straight after frame end");

    // Mid-frame pixels keep the stream open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_frame_end) |=> s_ready)
        else $error("stream stalled inside a frame");

    // A detection always comes with at least one red pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_detected) |-> (m_red_total != '0))
        else $error("detection reported with empty red count");
`endif

endmodule

[tb/tb_red_blob_centroid_motion_unit.sv]
// Self-checking testbench for the red blob centroid motion unit.
// Depends on rbcm_pkg and red_blob_centroid_motion_unit; drives random and directed pixel frames.
`timescale 1ns / 1ps

module tb_red_blob_centroid_motion_unit;
    import rbcm_pkg::*;

    localparam int ROW_W         = 11;
    localparam int COL_W         = 10;
    localparam int ROW_MAX       = (1 << ROW_W) - 1;
    localparam int COL_MAX       = (1 << COL_W) - 1;
    // Frame-end work is over once the last result has left;
    // pause a little more before touching registers
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_GAP       = 6;

    typedef struct packed {
        logic               detected;
        logic               moved;
        logic [ROW_W-1:0]   center_row;
        logic [COL_W-1:0]   center_col;
        logic [COUNT_W-1:0] red_total;
    } centroid_result_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #1 aclk = ~aclk;

    // Block inputs, all known from time zero
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_MIN_RED_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic [COLOUR_W-1:0]   s_red       = '0;
    logic [COLOUR_W-1:0]   s_green     = '0;
    logic [COLOUR_W-1:0]   s_blue      = '0;
    logic [ROW_W-1:0]      s_pixel_row = '0;
    logic [COL_W-1:0]      s_pixel_col = '0;
    logic                  s_frame_end = 1'b0;
    logic                  m_ready     = 1'b0;

    // Block outputs
    logic                  cfg_ready;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_detected;
    logic                  m_moved;
    logic [ROW_W-1:0]      m_center_row;
    logic [COL_W-1:0]      m_center_col;
    logic [COUNT_W-1:0]    m_red_total;

    red_blob_centroid_motion_unit #(
        .ROW_BITS (ROW_W),
        .COL_BITS (COL_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .s_pixel_row  (s_pixel_row),
        .s_pixel_col  (s_pixel_col),
        .s_frame_end  (s_frame_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_detected   (m_detected),
        .m_moved      (m_moved),
        .m_center_row (m_center_row),
        .m_center_col (m_center_col),
        .m_red_total  (m_red_total)
    );

    // Tracker copy: registers and per-frame state
    logic [COUNT_W-1:0]  trk_min_count  = RST_MIN_RED_COUNT;
    logic [THRESH_W-1:0] trk_move_thr   = RST_MOVE_THRESHOLD;
    logic [INTEN_W-1:0]  trk_inten_lo   = RST_INTENSITY_LOW;
    logic [INTEN_W-1:0]  trk_inten_hi   = RST_INTENSITY_HIGH;
    logic [COUNT_W-1:0]  trk_red_count  = '0;
    logic [SUM_W-1:0]    trk_row_sum    = '0;
    logic [SUM_W-1:0]    trk_col_sum    = '0;
    logic [ROW_W-1:0]    trk_last_row   = '0;
    logic [COL_W-1:0]    trk_last_col   = '0;
    logic                trk_have_last  = 1'b0;
    logic                trk_moved      = 1'b0;

    centroid_result_t pending_centroids[$];
    int               mismatch_count = 0;
    int               results_seen   = 0;

    // Shared controls for the idling processes
    bit no_gaps     = 1'b0;
    bit hold_req    = 1'b0;
    int hold_cycles = 0;

    // Classify one accepted pixel, accumulate, and on frame end queue the centroid result
    function automatic void update_blob_tracker(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                                logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                                logic last);
        logic [INTEN_W-1:0] inten;
        logic [13:0]        red20, inten9, red10, green13, blue13;
        logic [COUNT_W:0]   next_count;
        logic [SUM_W:0]     next_row_sum, next_col_sum;
        logic [SUM_W-1:0]   quo_row, quo_col;
        logic [ROW_W-1:0]   d_row;
        logic [COL_W-1:0]   d_col;
        logic [23:0]        disp;
        centroid_result_t   res;

        inten   = INTEN_W'(r) + INTEN_W'(g) + INTEN_W'(b);
        red20   = 14'(r) * 14'd20;
        inten9  = 14'(inten) * 14'd9;
        red10   = 14'(r) * 14'd10;
        green13 = 14'(g) * 14'd13;
        blue13  = 14'(b) * 14'd13;

        // Accumulate red pixels, saturating every total
        if (inten > trk_inten_lo && inten < trk_inten_hi && red20 > inten9 &&
            red10 > green13 && red10 > blue13) begin
            next_count    = {1'b0, trk_red_count} + 1'b1;
            next_row_sum  = {1'b0, trk_row_sum} + (SUM_W+1)'(row);
            next_col_sum  = {1'b0, trk_col_sum} + (SUM_W+1)'(col);
            trk_red_count = next_count[COUNT_W] ? '1 : next_count[COUNT_W-1:0];
            trk_row_sum   = next_row_sum[SUM_W] ? '1 : next_row_sum[SUM_W-1:0];
            trk_col_sum   = next_col_sum[SUM_W] ? '1 : next_col_sum[SUM_W-1:0];
        end

        if (!last)
            return;

        res.red_total = trk_red_count;
        res.detected  = trk_red_count > trk_min_count;
        if (res.detected) begin
            quo_row = trk_row_sum / SUM_W'(trk_red_count);
            quo_col = trk_col_sum / SUM_W'(trk_red_count);
            res.center_row = (quo_row > SUM_W'(ROW_MAX)) ? ROW_W'(ROW_MAX) : quo_row[ROW_W-1:0];
            res.center_col = (quo_col > SUM_W'(COL_MAX)) ? COL_W'(COL_MAX) : quo_col[COL_W-1:0];
            // Moved test only once a previous centroid exists
            if (trk_have_last) begin
                d_row = (res.center_row > trk_last_row) ? res.center_row - trk_last_row
                                                        : trk_last_row - res.center_row;
                d_col = (res.center_col > trk_last_col) ? res.center_col - trk_last_col
                                                        : trk_last_col - res.center_col;
                disp  = 24'(d_row) * 24'(d_row) + 24'(d_col) * 24'(d_col);
                trk_moved = disp > 24'(trk_move_thr);
            end
            trk_last_row  = res.center_row;
            trk_last_col  = res.center_col;
            trk_have_last = 1'b1;
        end else begin
            res.center_row = trk_last_row;
            res.center_col = trk_last_col;
        end
        res.moved = trk_moved;
        pending_centroids.push_back(res);

        trk_red_count = '0;
        trk_row_sum   = '0;
        trk_col_sum   = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    // Compare each result transaction with the oldest pending centroid
    always @(posedge aclk) begin : check_results
        centroid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_centroids.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = pending_centroids.pop_front();
                if (m_detected !== want.detected)
                    report_mismatch($sformatf("detected got %0b want %0b",
                                              m_detected, want.detected));
                if (m_moved !== want.moved)
                    report_mismatch($sformatf("moved got %0b want %0b", m_moved, want.moved));
                if (m_center_row !== want.center_row)
                    report_mismatch($sformatf("center_row got %0d want %0d",
                                              m_center_row, want.center_row));
                if (m_center_col !== want.center_col)
                    report_mismatch($sformatf("center_col got %0d want %0d",
                                              m_center_col, want.center_col));
                if (m_red_total !== want.red_total)
                    report_mismatch($sformatf("red_total got %0d want %0d",
                                              m_red_total, want.red_total));
            end
            results_seen++;
        end
    end

    // Result side: random stalls per transaction, plus a long hold on request
    initial begin : result_sink
        int stall;
        int hold_count;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                for (hold_count = 0; hold_count < hold_cycles; hold_count++)
                    @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && !hold_req);
        end
    end

    // Offer one pixel after a random gap; valid stays up when the next gap is zero
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input int row, input int col, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_red       <= r;
        s_green     <= g;
        s_blue      <= b;
        s_pixel_row <= ROW_W'(row);
        s_pixel_col <= COL_W'(col);
        s_frame_end <= last;
        do @(posedge aclk); while (!s_ready);
        update_blob_tracker(r, g, b, ROW_W'(row), COL_W'(col), last);
    endtask

    // Stop offering pixels, wait for every pending result and let the block settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_centroids.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; valid is left high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MIN_RED_COUNT:  trk_min_count = val[COUNT_W-1:0];
            REG_MOVE_THRESHOLD: trk_move_thr  = val[THRESH_W-1:0];
            REG_INTENSITY_LOW:  trk_inten_lo  = val[INTEN_W-1:0];
            REG_INTENSITY_HIGH: trk_inten_hi  = val[INTEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int min_count, input int move_thr, input int lo, input int hi);
        drain_results();
        write_reg(REG_MIN_RED_COUNT,  CFG_DATA_W'(min_count));
        write_reg(REG_MOVE_THRESHOLD, CFG_DATA_W'(move_thr));
        write_reg(REG_INTENSITY_LOW,  CFG_DATA_W'(lo));
        write_reg(REG_INTENSITY_HIGH, CFG_DATA_W'(hi));
        cfg_valid <= 1'b0;
    endtask

    function automatic int clamp(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // Mostly reddish pixels, some on the ratio boundaries, some plain noise
    function automatic void pick_colour(output logic [7:0] r, output logic [7:0] g,
                                        output logic [7:0] b);
        int kind;
        int rv;
        kind = $urandom_range(0, 9);
        rv   = $urandom_range(16, 255);
        r    = 8'(rv);
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                g = 8'($urandom_range(0, (10 * rv - 1) / 13));
                b = 8'($urandom_range(0, (10 * rv - 1) / 13));
            end
            6, 7: begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
            8: begin
                g = 8'((10 * rv) / 13 - $urandom_range(0, 1));
                b = 8'((10 * rv) / 13 - $urandom_range(0, 1));
            end
            default: begin
                r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        endcase
    endfunction

    // One frame of n pixels clustered round a centre, with some scattered noise
    task automatic send_frame(input int n, input int ctr_row, input int ctr_col,
                              input int spread);
        logic [7:0] r, g, b;
        int         row, col;
        for (int i = 0; i < n; i++) begin
            pick_colour(r, g, b);
            if ($urandom_range(0, 9) == 0) begin
                row = $urandom_range(0, ROW_MAX);
                col = $urandom_range(0, COL_MAX);
            end else begin
                row = clamp(ctr_row + $urandom_range(0, 2 * spread) - spread, ROW_MAX);
                col = clamp(ctr_col + $urandom_range(0, 2 * spread) - spread, COL_MAX);
            end
            send_pixel(r, g, b, row, col, i == n - 1);
        end
    endtask

    // Reset register values: field extremes and the intensity window edges, too few to detect
    task automatic test_reset_values();
        send_pixel(8'd255, 8'd0,   8'd0,   ROW_MAX, COL_MAX, 1'b0);
        send_pixel(8'd31,  8'd0,   8'd0,   0,       0,       1'b0);
        send_pixel(8'd30,  8'd0,   8'd0,   1,       1,       1'b0);
        send_pixel(8'd255, 8'd72,  8'd72,  1024,    512,     1'b0);
        send_pixel(8'd255, 8'd73,  8'd72,  1024,    512,     1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 7,       9,       1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   0,       0,       1'b1);
    endtask

    // Register extremes: first detection, moved set and cleared, no detection, a dead window
    task automatic test_register_extremes();
        set_config(0, 0, 0, 765);
        send_pixel(8'd255, 8'd0,  8'd0,  100,     200,     1'b1);
        send_pixel(8'd255, 8'd0,  8'd0,  101,     200,     1'b1);
        // Ratio boundaries: equal products are not red
        send_pixel(8'd90,  8'd55, 8'd55, 300,     300,     1'b0);
        send_pixel(8'd90,  8'd55, 8'd54, 101,     200,     1'b0);
        send_pixel(8'd130, 8'd100, 8'd0, 400,     400,     1'b0);
        send_pixel(8'd130, 8'd99, 8'd0,  101,     200,     1'b1);
        set_config(0, 8388607, 0, 765);
        send_pixel(8'd0,   8'd0,  8'd0,  50,      50,      1'b1);
        send_pixel(8'd255, 8'd0,  8'd0,  ROW_MAX, COL_MAX, 1'b1);
        // Inverted window: nothing can be red
        set_config(0, 100, 765, 0);
        send_pixel(8'd255, 8'd0,  8'd0,  5,       5,       1'b0);
        send_pixel(8'd200, 8'd0,  8'd0,  6,       6,       1'b1);
        // Unreachable minimum count
        set_config(2097152, 0, 0, 765);
        send_pixel(8'd255, 8'd0,  8'd0,  9,       9,       1'b0);
        send_pixel(8'd255, 8'd0,  8'd0,  10,      10,      1'b1);
    endtask

    // Random frames in several register settings; a blob that stays, creeps or jumps
    task automatic test_random_frames();
        int cur_row, cur_col, n, phase_items, spread;
        cur_row = $urandom_range(0, ROW_MAX);
        cur_col = $urandom_range(0, COL_MAX);
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_config(0, 0, 0, 765);
                1: set_config(2, RST_MOVE_THRESHOLD, RST_INTENSITY_LOW, RST_INTENSITY_HIGH);
                3: set_config($urandom_range(10, 20), $urandom_range(0, 60),
                              $urandom_range(0, 80), $urandom_range(250, 765));
                default: set_config($urandom_range(0, 8),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607)
                                                                : $urandom_range(0, 60),
                                    $urandom_range(0, 80), $urandom_range(250, 765));
            endcase
            no_gaps     = (p == 5);
            phase_items = 0;
            while (phase_items < 200) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: begin
                        cur_row = clamp(cur_row + $urandom_range(0, 6) - 3, ROW_MAX);
                        cur_col = clamp(cur_col + $urandom_range(0, 6) - 3, COL_MAX);
                    end
                    2: begin
                        cur_row = $urandom_range(0, ROW_MAX);
                        cur_col = $urandom_range(0, COL_MAX);
                    end
                    default: begin
                        cur_row = clamp(cur_row + $urandom_range(0, 30) - 15, ROW_MAX);
                        cur_col = clamp(cur_col + $urandom_range(0, 30) - 15, COL_MAX);
                    end
                endcase
                n      = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
                spread = $urandom_range(0, 3);
                send_frame(n, cur_row, cur_col, spread);
                phase_items += n;
            end
            no_gaps = 1'b0;
        end
    endtask

    // Hold the result side for a long stretch while short frames keep arriving
    task automatic test_output_backpressure();
        set_config(1, 50, 20, 600);
        hold_cycles = 300;
        hold_req    = 1'b1;
        for (int i = 0; i < 15; i++)
            send_frame(3, $urandom_range(0, ROW_MAX), $urandom_range(0, COL_MAX), 2);
        // Sender waits for every result before carrying on
        drain_results();
        for (int i = 0; i < 5; i++)
            send_frame(4, $urandom_range(0, ROW_MAX), $urandom_range(0, COL_MAX), 1);
    endtask

    initial begin : run_tests
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_random_frames();
        test_output_backpressure();
        drain_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Give up on a hung run
    initial begin : watchdog
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
sv/rbcm_pkg.sv
sv/rbcm_ctrl.sv
sv/rbcm_datapath.sv
sv/red_blob_centroid_motion_unit.sv
tb/tb_red_blob_centroid_motion_unit.sv
